// ----- rtl/core/euclidean_distance_unit_macros.svh -----
// Assertion macros shared by the Euclidean distance unit RTL.
`ifndef EUCLIDEAN_DISTANCE_UNIT_MACROS_SVH
`define EUCLIDEAN_DISTANCE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define EDU_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("euclidean distance unit: check failed");
// Next-cycle implication check.
`define EDU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("euclidean distance unit: check failed");
`else
`define EDU_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define EDU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/edu_pkg.sv -----
// Shared widths, constants and the square-root cell record for the distance unit.
`default_nettype none
package edu_pkg;
   localparam int ACC_W  = 48;
   localparam int ROOT_W = 24;
   localparam int REM_W  = ROOT_W + 2;

   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

   // One square-root stage: remaining radicand, partial remainder and root
   typedef struct packed {
      logic              valid;
      logic              sat;
      logic [ACC_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } edu_cell_type;
endpackage
`default_nettype wire

// ----- rtl/core/euclidean_distance_unit.sv -----
// Euclidean distance unit: top level with sum-of-squares front end and root cell chain.
//
// Usage:
//   Requests arrive on req_* one dimension each: both points' signed Q8.8
//   coordinates and req_last_dim on the final dimension of a point pair.
//   A request is taken when req_valid is high and req_stall is low.
//   On each last dimension one response leaves on rsp_*: the floor square
//   root of the summed squared differences (unsigned Q16.8) and a flag that
//   the 48-bit sum saturated within the pair. Other requests give no response.
// Timing:
//   One request per cycle is taken while the response side flows. A response
//   leaves after its last request passes three front-end stages (difference,
//   square, accumulate) and a chain of 24 root cells, one root bit per cell.
// Reset and stall:
//   Synchronous reset empties the pipeline and clears the sum. While a
//   response is held by rsp_stall the whole pipeline freezes and req_stall
//   is raised, so nothing is lost.
`default_nettype none
`include "euclidean_distance_unit_macros.svh"
module euclidean_distance_unit
   import edu_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [COORD_WIDTH-1:0] req_this_coord,
   input  wire logic [COORD_WIDTH-1:0] req_other_coord,
   input  wire logic                   req_last_dim,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [ROOT_W-1:0]           rsp_distance,
   output logic                        rsp_saturated
);
   edu_cell_type link [ROOT_W+1];
   logic         en;

   // Freeze everything while a finished response waits
   assign en        = !(link[ROOT_W].valid && rsp_stall);
   assign req_stall = !en;

   edu_sos #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_sos (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .req_valid   (req_valid),
      .this_coord  (req_this_coord),
      .other_coord (req_other_coord),
      .last_dim    (req_last_dim),
      .launch      (link[0])
   );

   // Chain of root cells, one result bit each
   for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
      edu_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .cell_i (link[i]),
         .cell_o (link[i+1])
      );
   end

   assign rsp_valid     = link[ROOT_W].valid;
   assign rsp_distance  = link[ROOT_W].root;
   assign rsp_saturated = link[ROOT_W].sat;

   // A saturated pair reports the full-scale distance
   `EDU_ASSERT_SAME(a_sat_dist, clock, reset, rsp_valid && rsp_saturated, rsp_distance == {ROOT_W{1'b1}})
endmodule
`default_nettype wire

// ----- rtl/core/edu_cell.sv -----
// One square-root cell: resolves a single root bit and hands the result onward.
`default_nettype none
`include "euclidean_distance_unit_macros.svh"
module edu_cell
   import edu_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire edu_cell_type cell_i,
   output edu_cell_type      cell_o
);
   edu_cell_type cell_ff;
   edu_cell_type cell_in;

   logic [REM_W+1:0] rem_sh;
   logic [REM_W+1:0] trial;
   logic [REM_W+1:0] diff;

   // Bring down the next two radicand bits and try the next root bit
   always_comb begin
      rem_sh = {cell_i.rem, cell_i.rad[ACC_W-1 -: 2]};
      trial  = {2'b00, cell_i.root, 2'b01};
      diff   = rem_sh - trial;
      cell_in       = cell_i;
      cell_in.rad   = {cell_i.rad[ACC_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         cell_in.rem  = diff[REM_W-1:0];
         cell_in.root = {cell_i.root[ROOT_W-2:0], 1'b1};
      end else begin
         cell_in.rem  = rem_sh[REM_W-1:0];
         cell_in.root = {cell_i.root[ROOT_W-2:0], 1'b0};
      end
   end

   // Advance the cell when the chain moves
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_o = cell_ff;

   // Remainder never exceeds twice the partial root
   `EDU_ASSERT_SAME(a_rem_bound, clock, reset, cell_ff.valid, cell_ff.rem <= {1'b0, cell_ff.root, 1'b0})
endmodule
`default_nettype wire

// ----- rtl/core/edu_sos.sv -----
// Front end: coordinate difference, square and saturating sum of squares.
`default_nettype none
`include "euclidean_distance_unit_macros.svh"
module edu_sos
   import edu_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   req_valid,
   input  wire logic [COORD_WIDTH-1:0] this_coord,
   input  wire logic [COORD_WIDTH-1:0] other_coord,
   input  wire logic                   last_dim,
   output edu_cell_type                launch
);
   localparam int MAG_W = COORD_WIDTH + 1;
   localparam int SQ_W  = 2 * MAG_W;
   localparam int SUM_W = ((SQ_W > ACC_W) ? SQ_W : ACC_W) + 1;

   logic             v1_ff, last1_ff;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic             v2_ff, last2_ff;
   logic [SQ_W-1:0]  sq_ff;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             ovf_ff, ovf_in;
   edu_cell_type     launch_ff, launch_in;

   logic [MAG_W-1:0] d;
   logic [SUM_W-1:0] sum;
   logic [ACC_W-1:0] acc_upd;
   logic             ovf_upd;

   // Magnitude of the coordinate difference
   always_comb begin
      d      = {this_coord[COORD_WIDTH-1], this_coord}
             - {other_coord[COORD_WIDTH-1], other_coord};
      mag_in = d[MAG_W-1] ? (~d + MAG_W'(1)) : d;
   end

   // Add the square, saturate, and launch the root on the last dimension
   always_comb begin
      sum     = SUM_W'(acc_ff) + SUM_W'(sq_ff);
      ovf_upd = ovf_ff;
      acc_upd = acc_ff;
      if (sum > SUM_W'(ACC_MAX)) begin
         acc_upd = ACC_MAX;
         ovf_upd = 1'b1;
      end else begin
         acc_upd = sum[ACC_W-1:0];
      end
      acc_in          = acc_ff;
      ovf_in          = ovf_ff;
      launch_in       = '0;
      launch_in.rad   = acc_upd;
      launch_in.sat   = ovf_upd;
      launch_in.valid = v2_ff && last2_ff;
      if (v2_ff) begin
         if (last2_ff) begin
            acc_in = '0;
            ovf_in = 1'b0;
         end else begin
            acc_in = acc_upd;
            ovf_in = ovf_upd;
         end
      end
   end

   // Advance the front-end stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         acc_ff          <= '0;
         ovf_ff          <= 1'b0;
         launch_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff     <= req_valid;
         v2_ff     <= v1_ff;
         acc_ff    <= acc_in;
         ovf_ff    <= ovf_in;
         launch_ff <= launch_in;
      end
   end

   // Hold the payload stages with the chain
   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff   <= mag_in;
         last1_ff <= last_dim;
         sq_ff    <= SQ_W'(mag_ff) * SQ_W'(mag_ff);
         last2_ff <= last1_ff;
      end
   end

   assign launch = launch_ff;

   // A saturated pair pins the accumulator at full scale
   `EDU_ASSERT_SAME(a_sat_full, clock, reset, ovf_ff, acc_ff == ACC_MAX)
   // Finishing a pair clears the accumulator and the overflow flag
   `EDU_ASSERT_NEXT(a_pair_clear, clock, reset, en && v2_ff && last2_ff, (acc_ff == '0) && !ovf_ff)
endmodule
`default_nettype wire
